### sv/weighted_interval_scheduling_defines.svh
// assertion macros for the weighted interval scheduling block
`ifndef WEIGHTED_INTERVAL_SCHEDULING_DEFINES_SVH
`define WEIGHTED_INTERVAL_SCHEDULING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WIS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WIS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WIS_ASSERT(label, clk, rstn, prop, msg)
`define WIS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### sv/wis_pkg.sv
package wis_pkg;
    localparam int MaxJobs = 1024;
    localparam int IdxW = $clog2(MaxJobs);
    localparam int CntW = IdxW + 1;
    localparam int TimeW = 31;
    localparam int PriceW = 20;
    localparam int ProfitW = 30;
    localparam logic [ProfitW-1:0] ProfitTop = {ProfitW{1'b1}};

    // one stored job, ordered by start, then length, then price
    typedef struct packed {
        logic [TimeW-1:0]  start;
        logic [TimeW-1:0]  length;
        logic [PriceW-1:0] price;
    } job_t;

    localparam int JobW = $bits(job_t);

    // the single shared comparator: a strictly below b in sort order
    function automatic logic job_less(input job_t a, input job_t b);
        return {a.start, a.length, a.price} < {b.start, b.length, b.price};
    endfunction

    function automatic logic [ProfitW-1:0] sat_add(input logic [PriceW-1:0] p,
                                                   input logic [ProfitW-1:0] q);
        logic [ProfitW:0] s;
        s = {1'b0, q} + {{(ProfitW+1-PriceW){1'b0}}, p};
        return s[ProfitW] ? ProfitTop : s[ProfitW-1:0];
    endfunction
endpackage

### sv/wis_job_ram.sv
module wis_job_ram
    import wis_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IdxW-1:0]     wr_addr,
    input  job_t                wr_data,
    input  logic [IdxW-1:0]     rd_addr,
    output job_t                rd_data
);
    job_t mem [MaxJobs];

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/wis_best_ram.sv
module wis_best_ram
    import wis_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IdxW-1:0]     wr_addr,
    input  logic [ProfitW-1:0]  wr_data,
    input  logic [IdxW-1:0]     rd_addr,
    output logic [ProfitW-1:0]  rd_data
);
    logic [ProfitW-1:0] mem [MaxJobs];

    // best profit from each sorted job onward
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/weighted_interval_scheduling.sv
// a set of n jobs returns its beat after the last job, an insertion sort and a
//   backward scan, all paced by one job memory port and one shared comparator
// throughput: one job per cycle while loading; not ready during sort, scan and result hold
// reset: aresetn synchronous active low clears the job count and the sequencer;
//   the memories keep their contents and need no clearing pass
`include "weighted_interval_scheduling_defines.svh"
module weighted_interval_scheduling
    import wis_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TimeW-1:0]    s_job_start,
    input  logic [TimeW-1:0]    s_job_length,
    input  logic [PriceW-1:0]   s_job_price,
    input  logic                s_last_job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ProfitW-1:0]  m_best_profit
);
    typedef enum logic [10:0] {
        ST_LOAD    = 11'b00000000001,
        ST_S_RDA   = 11'b00000000010,
        ST_S_RDB   = 11'b00000000100,
        ST_S_CMP   = 11'b00000001000,
        ST_S_WR    = 11'b00000010000,
        ST_D_RDI   = 11'b00000100000,
        ST_D_WAITI = 11'b00001000000,
        ST_D_RDJ   = 11'b00010000000,
        ST_D_CHK   = 11'b00100000000,
        ST_D_BEST  = 11'b01000000000,
        ST_OUT     = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic [CntW-1:0]    i_reg, i_next;
    logic [CntW-1:0]    k_reg, k_next;
    logic [CntW-1:0]    j_reg, j_next;
    job_t               a_reg, a_next;
    logic [TimeW:0]     end_reg, end_next;
    logic [PriceW-1:0]  price_reg, price_next;
    logic [ProfitW-1:0] skip_reg, skip_next;
    logic [ProfitW-1:0] after_reg, after_next;
    logic               found_reg, found_next;
    logic [ProfitW-1:0] result_reg, result_next;

    logic               jw_en;
    logic [IdxW-1:0]    jw_addr, jr_addr;
    job_t               jw_data, jr_data;
    logic               bw_en;
    logic [IdxW-1:0]    bw_addr, br_addr;
    logic [ProfitW-1:0] bw_data, br_data;
    logic [ProfitW-1:0] take;

    wis_job_ram u_job_ram (
        .aclk    (aclk),
        .wr_en   (jw_en),
        .wr_addr (jw_addr),
        .wr_data (jw_data),
        .rd_addr (jr_addr),
        .rd_data (jr_data)
    );

    wis_best_ram u_best_ram (
        .aclk    (aclk),
        .wr_en   (bw_en),
        .wr_addr (bw_addr),
        .wr_data (bw_data),
        .rd_addr (br_addr),
        .rd_data (br_data)
    );

    assign s_ready       = (state_reg == ST_LOAD);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_best_profit = result_reg;
    assign take          = sat_add(price_reg, found_reg ? after_reg : '0);

    // sequencer: load, insertion sort, backward scan, result
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        a_next      = a_reg;
        end_next    = end_reg;
        price_next  = price_reg;
        skip_next   = skip_reg;
        after_next  = after_reg;
        found_next  = found_reg;
        result_next = result_reg;
        jw_en       = 1'b0;
        jw_addr     = count_reg[IdxW-1:0];
        jw_data     = '{start: s_job_start, length: s_job_length, price: s_job_price};
        jr_addr     = k_reg[IdxW-1:0];
        bw_en       = 1'b0;
        bw_addr     = i_reg[IdxW-1:0];
        bw_data     = (take > skip_reg) ? take : skip_reg;
        br_addr     = j_reg[IdxW-1:0];
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CntW'(MaxJobs)) begin
                        jw_en = 1'b1;
                    end
                    count_next = (count_reg < CntW'(MaxJobs)) ? count_reg + 1'b1 : count_reg;
                    if (s_last_job) begin
                        i_next     = CntW'(1);
                        k_next     = CntW'(1);
                        state_next = ST_S_RDA;
                    end
                end
            end
            ST_S_RDA: begin
                // k is the element moving down
                if (i_reg >= count_reg) begin
                    i_next      = count_reg;
                    skip_next   = '0;
                    result_next = '0;
                    state_next  = (count_reg == '0) ? ST_OUT : ST_D_RDI;
                end else if (k_reg == '0) begin
                    i_next     = i_reg + 1'b1;
                    k_next     = i_reg + 1'b1;
                end else begin
                    jr_addr    = k_reg[IdxW-1:0];
                    state_next = ST_S_RDB;
                end
            end
            ST_S_RDB: begin
                a_next     = jr_data;
                jr_addr    = IdxW'(k_reg - 1'b1);
                state_next = ST_S_CMP;
            end
            ST_S_CMP: begin
                if (job_less(a_reg, jr_data)) begin
                    jw_en      = 1'b1;
                    jw_addr    = k_reg[IdxW-1:0];
                    jw_data    = jr_data;
                    state_next = ST_S_WR;
                end else begin
                    i_next     = i_reg + 1'b1;
                    k_next     = i_reg + 1'b1;
                    state_next = ST_S_RDA;
                end
            end
            ST_S_WR: begin
                jw_en      = 1'b1;
                jw_addr    = IdxW'(k_reg - 1'b1);
                jw_data    = a_reg;
                k_next     = k_reg - 1'b1;
                state_next = ST_S_RDA;
            end
            ST_D_RDI: begin
                // i_reg counts down; i_reg is one past the job under work
                if (i_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    jr_addr    = IdxW'(i_reg - 1'b1);
                    state_next = ST_D_WAITI;
                end
            end
            ST_D_WAITI: begin
                end_next   = {1'b0, jr_data.start} + {1'b0, jr_data.length};
                price_next = jr_data.price;
                found_next = 1'b0;
                after_next = '0;
                j_next     = i_reg;
                state_next = ST_D_RDJ;
            end
            ST_D_RDJ: begin
                if (j_reg >= count_reg) begin
                    state_next = ST_D_BEST;
                end else begin
                    jr_addr    = j_reg[IdxW-1:0];
                    br_addr    = j_reg[IdxW-1:0];
                    state_next = ST_D_CHK;
                end
            end
            ST_D_CHK: begin
                if ({1'b0, jr_data.start} >= end_reg) begin
                    found_next = 1'b1;
                    after_next = br_data;
                    state_next = ST_D_BEST;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_D_RDJ;
                end
            end
            ST_D_BEST: begin
                bw_en       = 1'b1;
                bw_addr     = IdxW'(i_reg - 1'b1);
                skip_next   = bw_data;
                result_next = bw_data;
                i_next      = i_reg - 1'b1;
                state_next  = ST_D_RDI;
            end
            ST_OUT: begin
                if (m_ready) begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        i_reg      <= i_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        a_reg      <= a_next;
        end_reg    <= end_next;
        price_reg  <= price_next;
        skip_reg   <= skip_next;
        after_reg  <= after_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    `WIS_ASSERT(a_count_max, aclk, aresetn, count_reg <= CntW'(MaxJobs), "job count overflow")
    `WIS_ASSERT(a_onehot, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `WIS_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_best_profit), "result dropped")
    `WIS_ASSERT(a_busy, aclk, aresetn, s_valid && s_ready && s_last_job |=> !s_ready, "ready during work")
endmodule

### sim/tb.sv
module tb;
    import wis_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TimeW-1:0]    s_job_start = '0;
    logic [TimeW-1:0]    s_job_length = '0;
    logic [PriceW-1:0]   s_job_price = '0;
    logic                s_last_job = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ProfitW-1:0]  m_best_profit;

    weighted_interval_scheduling uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_job_start(s_job_start), .s_job_length(s_job_length),
        .s_job_price(s_job_price), .s_last_job(s_last_job),
        .m_valid(m_valid), .m_ready(m_ready), .m_best_profit(m_best_profit)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // jobs of the set being loaded, and profits still owed by the block
    job_t              loaded_jobs[$];
    logic [ProfitW-1:0] profit_queue[$];
    int                errors = 0;
    int                send_idle = 0;
    int                recv_stall = 0;

    // directed rows; check_exp marks a hand-computed profit
    typedef struct {
        logic [TimeW-1:0]   start;
        logic [TimeW-1:0]   length;
        logic [PriceW-1:0]  price;
        logic               last;
        logic               check_exp;
        logic [ProfitW-1:0] exp_profit;
    } row_t;

    localparam logic [TimeW-1:0]  TMax = {TimeW{1'b1}};
    localparam logic [PriceW-1:0] PMax = {PriceW{1'b1}};

    row_t rows[] = '{
        '{0, 0, 0, 1, 1, 0},
        '{TMax, TMax, PMax, 1, 1, PMax},
        '{0, 0, 5, 1, 1, 5},
        '{0, 10, 7, 0, 0, 0},
        '{5, 10, 9, 0, 0, 0},
        '{10, 3, 4, 1, 0, 0},
        '{20, 5, 100, 0, 0, 0},
        '{20, 5, 100, 0, 0, 0},
        '{0, 20, 50, 0, 0, 0},
        '{0, 19, 60, 1, 0, 0},
        '{TMax, 0, 1, 0, 0, 0},
        '{TMax, TMax, 2, 0, 0, 0},
        '{0, TMax, PMax, 1, 0, 0},
        '{3, 1, PMax, 0, 0, 0},
        '{0, 3, 1, 0, 0, 0},
        '{1, 1, PMax, 1, 0, 0}
    };

    function automatic logic job_before(job_t a, job_t b);
        return {a.start, a.length, a.price} < {b.start, b.length, b.price};
    endfunction

    function automatic logic [ProfitW-1:0] add_sat(logic [ProfitW-1:0] a, logic [PriceW-1:0] b);
        logic [ProfitW:0] s;
        s = {1'b0, a} + b;
        return s[ProfitW] ? {ProfitW{1'b1}} : s[ProfitW-1:0];
    endfunction

    // sort the set and run the skip-or-take pass from the back
    function automatic logic [ProfitW-1:0] best_schedule(job_t jobs[$]);
        job_t               sorted[$];
        job_t               t;
        logic [ProfitW-1:0] best_from[];
        logic [ProfitW-1:0] skip, take, after;
        logic [TimeW:0]     finish;
        int                 n, k;
        sorted = jobs;
        n = sorted.size();
        if (n == 0) return '0;
        for (int i = 1; i < n; i++) begin
            k = i;
            while (k > 0 && job_before(sorted[k], sorted[k-1])) begin
                t = sorted[k]; sorted[k] = sorted[k-1]; sorted[k-1] = t;
                k--;
            end
        end
        best_from = new[n];
        for (int i = n - 1; i >= 0; i--) begin
            skip = (i + 1 < n) ? best_from[i+1] : '0;
            finish = {1'b0, sorted[i].start} + sorted[i].length;
            after = '0;
            for (int j = i + 1; j < n; j++) begin
                if ({1'b0, sorted[j].start} >= finish) begin
                    after = best_from[j];
                    break;
                end
            end
            take = add_sat(after, sorted[i].price);
            best_from[i] = take > skip ? take : skip;
        end
        return best_from[0];
    endfunction

    // one input beat; returns once it has been accepted
    task automatic send_job(logic [TimeW-1:0] st, logic [TimeW-1:0] ln,
                            logic [PriceW-1:0] pr, logic lst,
                            logic use_exp, logic [ProfitW-1:0] exp_val);
        job_t j;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_job_start <= st;
        s_job_length <= ln;
        s_job_price <= pr;
        s_last_job <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        j.start = st; j.length = ln; j.price = pr;
        if (loaded_jobs.size() < MaxJobs) loaded_jobs.insert(loaded_jobs.size(), j);
        if (lst) begin
            if (use_exp) profit_queue.insert(profit_queue.size(), exp_val);
            else profit_queue.insert(profit_queue.size(), best_schedule(loaded_jobs));
            loaded_jobs.delete();
        end
    endtask

    // result beats against the oldest expected profit
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (profit_queue.size() == 0) begin
                $display("%0t: unexpected profit beat %0d", $time, m_best_profit);
                errors++;
            end else begin
                if (m_best_profit !== profit_queue[0]) begin
                    $display("%0t: best_profit expected %0d actual %0d",
                             $time, profit_queue[0], m_best_profit);
                    errors++;
                end
                void'(profit_queue.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic set_phase(int p);
        case (p % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 62; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 62; end
            default: begin send_idle = 10; recv_stall = 10; end
        endcase
    endtask

    initial begin
        int sent, set_size, wait_cycles;
        logic [TimeW-1:0] st, ln;
        logic [PriceW-1:0] pr;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        foreach (rows[i])
            send_job(rows[i].start, rows[i].length, rows[i].price, rows[i].last,
                     rows[i].check_exp, rows[i].exp_profit);

        // random sets
        sent = 0;
        while (sent < 634) begin
            set_phase(sent / 80);
            set_size = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < set_size; k++) begin
                if ($urandom_range(9) == 0) begin
                    st = TimeW'($urandom); ln = TimeW'($urandom);
                end else begin
                    st = TimeW'($urandom_range(200)); ln = TimeW'($urandom_range(60));
                end
                pr = ($urandom_range(7) == 0) ? PMax : PriceW'($urandom);
                send_job(st, ln, pr, k == set_size - 1, 1'b0, '0);
                sent++;
            end
        end
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (profit_queue.size() != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (profit_queue.size() != 0) begin
            $display("%0t: %0d profits never arrived", $time, profit_queue.size());
            errors++;
        end
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

    initial begin
        #(8 * 3000000);
        $display("tb failed");
        $finish;
    end
endmodule

### weighted_interval_scheduling.f
+incdir+sv
sv/wis_pkg.sv
sv/wis_job_ram.sv
sv/wis_best_ram.sv
sv/weighted_interval_scheduling.sv
sim/tb.sv
